[src/mbe_pkg.sv]
// Shared types, constants and helper functions for the Mandelbrot escape-time block.
// Used by the channel interfaces, the register file, the multiplier and the top level.
// Depends on nothing.
package mbe_pkg;

  // Fixed-point format of coordinates and z components (signed Q4.28).
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;

  // Pixel index width and image dimension limit.
  localparam int IDX_W   = 10;
  localparam int MAX_DIM = 1024;

  // Iteration counter and magnitude widths.
  localparam int ITER_W = 16;
  localparam int MAG_W  = 36;

  // Full product, truncated square and pre-saturation sum widths.
  localparam int PROD_W = 2 * COORD_W;
  localparam int SQ_W   = PROD_W - 1 - FRAC_BITS;
  localparam int SUM_W  = COORD_W + IDX_W;

  // Bailout threshold |z|^2 = 4.0, held one bit wider than the magnitude.
  localparam logic [MAG_W:0] BAILOUT = (MAG_W + 1)'(4) << FRAC_BITS;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [ITER_W-1:0]         iter_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [MAG_W-1:0]          mag_t;

  // Reset values: origin -2.0, step 4/800, limit 50.
  localparam coord_t ORIGIN_RST = -32'sd536870912;
  localparam step_t  STEP_RST   = 31'd1342177;
  localparam iter_t  LIMIT_RST  = 16'd50;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP_REAL   = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } reg_idx_t;

  // Current configuration, handed from the register file to the datapath.
  typedef struct packed {
    coord_t origin_real;
    coord_t origin_imag;
    step_t  step_real;
    step_t  step_imag;
    iter_t  iteration_limit;
  } cfg_regs_t;

  // Saturate a wide signed sum to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] x);
    if ((&x[SUM_W-1:COORD_W-1]) || !(|x[SUM_W-1:COORD_W-1])) begin
      return x[COORD_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W - 1){1'b1}}};
    end
  endfunction

  // Limit a pixel index to the last valid column or row.
  function automatic idx_t clamp_index(input idx_t v);
    logic [IDX_W:0] wide;
    wide = {1'b0, v};
    if (wide >= (IDX_W + 1)'(MAX_DIM)) begin
      return IDX_W'(MAX_DIM - 1);
    end
    return v;
  endfunction

endpackage

[src/mbe_if.sv]
// Valid/ready channel interfaces for pixel beats in and escape results out.
// Depends on mbe_pkg for the field widths.
interface mbe_in_if;
  import mbe_pkg::*;

  logic valid;
  logic ready;
  idx_t column;
  idx_t row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbe_out_if;
  import mbe_pkg::*;

  logic  valid;
  logic  ready;
  iter_t iterations;
  logic  escaped;
  mag_t  final_magnitude_sq;

  modport source (output valid, output iterations, output escaped,
                  output final_magnitude_sq, input ready);
  modport sink   (input valid, input iterations, input escaped,
                  input final_magnitude_sq, output ready);
endinterface

[src/mbe_cfg.sv]
// APB-style configuration register file: origin, step and iteration limit.
// Depends on mbe_pkg for the register layout and reset values.
module mbe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mbe_pkg::cfg_regs_t              cfg
);
  import mbe_pkg::*;

  cfg_regs_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_real     <= ORIGIN_RST;
      cfg_r.origin_imag     <= ORIGIN_RST;
      cfg_r.step_real       <= STEP_RST;
      cfg_r.step_imag       <= STEP_RST;
      cfg_r.iteration_limit <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_REAL: cfg_r.origin_real     <= pwdata[COORD_W-1:0];
        REG_ORIGIN_IMAG: cfg_r.origin_imag     <= pwdata[COORD_W-1:0];
        REG_STEP_REAL:   cfg_r.step_real       <= pwdata[STEP_W-1:0];
        REG_STEP_IMAG:   cfg_r.step_imag       <= pwdata[STEP_W-1:0];
        REG_ITER_LIMIT:  cfg_r.iteration_limit <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux; unmapped addresses read as zero.
  always_comb begin
    unique case (idx)
      REG_ORIGIN_REAL: prdata = CFG_DATA_W'(cfg_r.origin_real);
      REG_ORIGIN_IMAG: prdata = CFG_DATA_W'(cfg_r.origin_imag);
      REG_STEP_REAL:   prdata = CFG_DATA_W'(cfg_r.step_real);
      REG_STEP_IMAG:   prdata = CFG_DATA_W'(cfg_r.step_imag);
      REG_ITER_LIMIT:  prdata = CFG_DATA_W'(cfg_r.iteration_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

[src/mbe_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the operand and product widths.
module mbe_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  mbe_pkg::coord_t                       a,
  input  mbe_pkg::coord_t                       b,
  output logic signed [mbe_pkg::PROD_W-1:0]     p_r
);
  import mbe_pkg::*;

  // One product per enabled cycle; the result holds otherwise.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

[src/mandelbrot_escape_iteration_top.sv]
// Mandelbrot escape-time engine: one pixel in, one iteration result out.
// Depends on mbe_pkg, mbe_if, mbe_cfg and mbe_mul.
//
// Usage: a beat on in_ch carries a pixel column and row. The block maps it to
// c = origin + index * step, iterates z = z^2 + c from zero until |z|^2 reaches
// 4.0 or the iteration limit is hit, and returns one beat on out_ch with the
// iteration count, the escaped flag and the final |z|^2 (unsigned Q8.28).
// Registers sit on the APB-style port; the user must write them only while
// the block is idle, since the block itself does not enforce this.
// Timing: in_ch is ready again in the cycle the result appears, so a new pixel
// is taken only after the last one is done. The single shared 32x32 multiplier
// bounds the rate: it forms two coordinate products at setup and three products
// (zx*zy, zx^2, zy^2) per iteration.
// The result waits in an output register; the next pixel is accepted and runs
// while it waits. If the receiver still stalls when the next result is done,
// the sequencer holds in its final state until the register frees up.
// Reset restores the default view (origin -2-2i, step 4/800, limit 50) and
// empties the output register.
module mandelbrot_escape_iteration_top (
  input  logic                            clk,
  input  logic                            rst_n,
  mbe_in_if.sink                          in_ch,
  mbe_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mbe_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_CRE  = 11'b000_0000_0010,
    S_CIM  = 11'b000_0000_0100,
    S_CSET = 11'b000_0000_1000,
    S_TEST = 11'b000_0001_0000,
    S_MXY  = 11'b000_0010_0000,
    S_UPD  = 11'b000_0100_0000,
    S_MXX  = 11'b000_1000_0000,
    S_MYY  = 11'b001_0000_0000,
    S_SQY  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t    state_r, state_nxt;
  cfg_regs_t cfg;

  idx_t   col_r, row_r;
  coord_t cx_r, cy_r, zx_r, zy_r;
  sq_t    zx2_r, zy2_r;
  iter_t  iter_r;

  logic                     out_valid_r, out_valid_nxt;
  iter_t                    out_iter_r;
  logic                     out_esc_r;
  mag_t                     out_mag_r;

  coord_t                   mul_a, mul_b;
  logic                     mul_en;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] p_sh;

  logic signed [SUM_W-1:0]  cx_sum, cy_sum, zx_sum, zy_sum;
  logic [MAG_W:0]           mag_wide;
  mag_t                     mag_sat;
  logic                     below_limit, keep_going, in_acc, out_load;

  // Configuration registers.
  mbe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared multiplier.
  mbe_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_en = 1'b1;
    unique case (state_r)
      S_CRE: begin
        mul_a = COORD_W'(col_r);
        mul_b = COORD_W'(cfg.step_real);
      end
      S_CIM: begin
        mul_a = COORD_W'(row_r);
        mul_b = COORD_W'(cfg.step_imag);
      end
      S_MXY: begin
        mul_a = zx_r;
        mul_b = zy_r;
      end
      S_MXX: begin
        mul_a = zx_r;
        mul_b = zx_r;
      end
      S_MYY: begin
        mul_a = zy_r;
        mul_b = zy_r;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  // Coordinate sums and the z update, all before saturation.
  always_comb begin
    p_sh   = mul_p >>> (FRAC_BITS - 1);
    cx_sum = SUM_W'(cfg.origin_real) + $signed(mul_p[SUM_W-1:0]);
    cy_sum = SUM_W'(cfg.origin_imag) + $signed(mul_p[SUM_W-1:0]);
    zy_sum = $signed(p_sh[SUM_W-1:0]) + SUM_W'(cy_r);
    zx_sum = $signed(SUM_W'(zx2_r)) - $signed(SUM_W'(zy2_r)) + SUM_W'(cx_r);
  end

  // Magnitude, bailout test and limit test.
  assign mag_wide    = (MAG_W + 1)'(zx2_r) + (MAG_W + 1)'(zy2_r);
  assign mag_sat     = mag_wide[MAG_W] ? '1 : mag_wide[MAG_W-1:0];
  assign below_limit = iter_r < cfg.iteration_limit;
  assign keep_going  = below_limit && (mag_wide < BAILOUT);

  // Handshakes.
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer next state.
  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = in_acc ? S_CRE : S_IDLE;
      S_CRE:   state_nxt = S_CIM;
      S_CIM:   state_nxt = S_CSET;
      S_CSET:  state_nxt = S_TEST;
      S_TEST:  state_nxt = keep_going ? S_MXY : S_DONE;
      S_MXY:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_MXX;
      S_MXX:   state_nxt = S_MYY;
      S_MYY:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_TEST;
      S_DONE:  state_nxt = out_load ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, written step by step; S_CSET clears z, the squares and the counter.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          col_r <= clamp_index(in_ch.column);
          row_r <= clamp_index(in_ch.row);
        end
      end
      S_CIM: cx_r <= sat_coord(cx_sum);
      S_CSET: begin
        cy_r   <= sat_coord(cy_sum);
        zx_r   <= '0;
        zy_r   <= '0;
        zx2_r  <= '0;
        zy2_r  <= '0;
        iter_r <= '0;
      end
      S_UPD: begin
        zy_r   <= sat_coord(zy_sum);
        zx_r   <= sat_coord(zx_sum);
        iter_r <= iter_r + ITER_W'(1);
      end
      S_MYY:   zx2_r <= mul_p[FRAC_BITS +: SQ_W];
      S_SQY:   zy2_r <= mul_p[FRAC_BITS +: SQ_W];
      default: ;
    endcase
  end

  // Output register.
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_iter_r <= iter_r;
      out_esc_r  <= below_limit;
      out_mag_r  <= mag_sat;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.iterations         = out_iter_r;
  assign out_ch.escaped            = out_esc_r;
  assign out_ch.final_magnitude_sq = out_mag_r;

  // An accepted pixel always starts the coordinate setup.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CRE))
    else $error("accepted pixel did not start coordinate setup");

  // The iteration counter never runs past the limit.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (iter_r <= cfg.iteration_limit))
    else $error("iteration counter exceeded the limit");

  // A result waiting on a full, stalled output register is held back.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result overwrote a stalled output beat");

  // An escaped result always reports fewer iterations than the limit.
  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_esc_r) |-> (out_iter_r < cfg.iteration_limit))
    else $error("escaped flag set at or beyond the iteration limit");

endmodule
